// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg
// shared types, sizes and helpers of the totient sieve table
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VAL_W       = 16;
  localparam int LIM_W       = 16;
  localparam int DIV_W       = ((ADDR_W > VAL_W) ? ADDR_W : VAL_W) + 1;
  localparam int DCNT_W      = $clog2(VAL_W + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [LIM_W-1:0]  lim_t;

  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABOVE     = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_DONE      = 2'd3
  } status_t;

  typedef struct packed {
    logic  start;
    val_t  dividend;
    addr_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    val_t quotient;
  } div_rsp_t;

  // 16-bit index onto the table address
  function automatic addr_t idx_to_addr(input lim_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[ADDR_W-1:0];
  endfunction

  // table address as a stored 16-bit value
  function automatic val_t addr_to_val(input addr_t a);
    logic [31:0] w;
    w = 32'(a);
    return w[VAL_W-1:0];
  endfunction

  // build limit clipped to the last table entry
  function automatic addr_t sat_limit(input lim_t v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(TABLE_DEPTH - 1)) begin
      w = 32'(TABLE_DEPTH - 1);
    end
    return w[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/ets_req_if.sv =====
// ----------------------------------------------------------------------------
// ets_req_if
// request channel: build or query, valid/ready handshake
// ----------------------------------------------------------------------------
interface ets_req_if import ets_pkg::*; ();

  logic valid;
  logic ready;
  logic req_type;
  lim_t query_index;

  modport source (output valid, output req_type, output query_index, input ready);
  modport sink   (input valid, input req_type, input query_index, output ready);

endinterface

// ===== src/ets_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ets_rsp_if
// result channel: totient value and status, valid/ready handshake
// ----------------------------------------------------------------------------
interface ets_rsp_if import ets_pkg::*; ();

  logic       valid;
  logic       ready;
  val_t       totient_value;
  logic [1:0] status;

  modport source (output valid, output totient_value, output status, input ready);
  modport sink   (input valid, input totient_value, input status, output ready);

endinterface

// ===== src/euler_totient_sieve_table.sv =====
// ----------------------------------------------------------------------------
// euler_totient_sieve_table
// Euler totient table built by a sieve in one RAM, queried one index per item
// ----------------------------------------------------------------------------
// A build item (req_type 0) fills the table with phi(k) for k = 0 .. limit,
// where limit is cfg_wdata last written, clipped to the last table entry,
// and answers with status "build done". A query item (req_type 1) answers
// with phi(query_index), or with status "not built" before the first build,
// or "above limit" when the index lies past the limit of the last build;
// a later limit write does not change the table until the next build.
// A query reads the table RAM at the accept edge; in S_RESP its result is
// loaded into the result register once that register is free. A build
// seeds phi[k] = k for k = 0 .. limit, then reads phi[i] to check each
// candidate i from 2 to limit, then for each multiple of each prime runs
// the single-port RAM read and the 1 bit per cycle divider that forms
// phi[j] / i before the write back. The whole build is serial on that
// read-divide-write loop; the next item is taken after the result is
// registered, and a result may wait at the output while a new item is
// accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_totient_sieve_table import ets_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  ets_req_if.sink        in_ch,
  ets_rsp_if.source      out_ch,
  input  logic           cfg_we,
  input  lim_t           cfg_wdata
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an item
    S_INIT,   // seed phi[j] = j
    S_PRD,    // read phi[i]
    S_PCHK,   // i prime when phi[i] still equals i
    S_JRD,    // read phi[j] for a multiple j of i
    S_JDIV,   // capture phi[j], start the divide
    S_JWAIT,  // wait for phi[j] / i, write back
    S_RESP    // load the result register
  } state_t;

  state_t  state_r;

  // configuration and build bookkeeping
  lim_t    table_limit_r;
  logic    built_r;
  addr_t   built_lim_r;
  addr_t   lim_r;
  addr_t   i_r;
  addr_t   j_r;
  val_t    val_r;
  status_t res_status_r;
  logic    res_rd_r;

  // result register
  logic    out_valid_r;
  val_t    out_value_r;
  status_t out_status_r;

  // table RAM
  val_t    mem [TABLE_DEPTH];
  logic    mem_rd_en;
  addr_t   mem_rd_addr;
  val_t    mem_rdata_r;
  logic    mem_we;
  val_t    mem_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic            in_fire;
  logic            out_free;
  logic            query_above;
  logic            query_ok;
  logic [ADDR_W:0] j_sum;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // the query index is checked against the limit of the last build
  assign query_above = (32'(in_ch.query_index) > 32'(built_lim_r));
  assign query_ok    = built_r && !query_above;

  // next multiple of the current prime, one bit wider to catch the wrap
  assign j_sum = {1'b0, j_r} + {1'b0, i_r};

  // --------------------------------------------------------------------------
  // RAM port control: reads for queries, prime checks and multiples
  // --------------------------------------------------------------------------
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = j_r;
    case (state_r)
      S_IDLE: begin
        mem_rd_en   = in_fire && (in_ch.req_type == REQ_QUERY) && query_ok;
        mem_rd_addr = idx_to_addr(in_ch.query_index);
      end
      S_PRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = i_r;
      end
      S_JRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = j_r;
      end
      default: begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = j_r;
      end
    endcase
  end

  // seeding writes the index itself, the sieve writes phi[j] - phi[j] / i
  assign mem_we    = (state_r == S_INIT) || ((state_r == S_JWAIT) && div_rsp.done);
  assign mem_wdata = (state_r == S_INIT) ? addr_to_val(j_r) : (val_r - div_rsp.quotient);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[j_r] <= mem_wdata;
    end
    if (mem_rd_en) begin
      mem_rdata_r <= mem[mem_rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // divider: phi[j] / i, started once per multiple
  // --------------------------------------------------------------------------
  assign div_req.start    = (state_r == S_JDIV);
  assign div_req.dividend = mem_rdata_r;
  assign div_req.divisor  = i_r;

  ets_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_limit_r <= '0;
    end else if (cfg_we) begin
      table_limit_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      built_r      <= 1'b0;
      built_lim_r  <= '0;
      out_valid_r  <= 1'b0;
      res_rd_r     <= 1'b0;
      res_status_r <= ST_OK;
    end else begin
      // in S_RESP the result register is reloaded in the same cycle
      if (out_valid_r && out_ch.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.req_type == REQ_BUILD) begin
              lim_r   <= sat_limit(table_limit_r);
              j_r     <= '0;
              state_r <= S_INIT;
            end else begin
              res_rd_r <= query_ok;
              if (!built_r) begin
                res_status_r <= ST_NOT_BUILT;
              end else if (query_above) begin
                res_status_r <= ST_ABOVE;
              end else begin
                res_status_r <= ST_OK;
              end
              state_r <= S_RESP;
            end
          end
        end
        S_INIT: begin
          if (j_r == lim_r) begin
            if (32'(lim_r) < 32'd2) begin
              // nothing to sieve for limits zero and one
              built_r      <= 1'b1;
              built_lim_r  <= lim_r;
              res_rd_r     <= 1'b0;
              res_status_r <= ST_DONE;
              state_r      <= S_RESP;
            end else begin
              i_r     <= ADDR_W'(2);
              state_r <= S_PRD;
            end
          end else begin
            j_r <= j_r + ADDR_W'(1);
          end
        end
        S_PRD: begin
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (mem_rdata_r == addr_to_val(i_r)) begin
            j_r     <= i_r;
            state_r <= S_JRD;
          end else if (i_r == lim_r) begin
            built_r      <= 1'b1;
            built_lim_r  <= lim_r;
            res_rd_r     <= 1'b0;
            res_status_r <= ST_DONE;
            state_r      <= S_RESP;
          end else begin
            i_r     <= i_r + ADDR_W'(1);
            state_r <= S_PRD;
          end
        end
        S_JRD: begin
          state_r <= S_JDIV;
        end
        S_JDIV: begin
          val_r   <= mem_rdata_r;
          state_r <= S_JWAIT;
        end
        S_JWAIT: begin
          if (div_rsp.done) begin
            if (j_sum > {1'b0, lim_r}) begin
              // last multiple done, move to the next candidate or finish the build
              if (i_r == lim_r) begin
                built_r      <= 1'b1;
                built_lim_r  <= lim_r;
                res_rd_r     <= 1'b0;
                res_status_r <= ST_DONE;
                state_r      <= S_RESP;
              end else begin
                i_r     <= i_r + ADDR_W'(1);
                state_r <= S_PRD;
              end
            end else begin
              j_r     <= j_sum[ADDR_W-1:0];
              state_r <= S_JRD;
            end
          end
        end
        S_RESP: begin
          // hold until the result register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_rd_r ? mem_rdata_r : '0;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.totient_value = out_value_r;
  assign out_ch.status        = out_status_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // table writes stay inside the range of the running build
  `ASSERT_SAME(a_wr_in_range, mem_we, (j_r <= lim_r) && (state_r == S_INIT || state_r == S_JWAIT))
  // sieve step never takes more than the entry holds
  `ASSERT_SAME(a_quo_le_val, (state_r == S_JWAIT) && div_rsp.done, div_rsp.quotient <= val_r)
  // a result that is not ok carries a zero value
  `ASSERT_SAME(a_zero_unless_ok, out_valid_r && (out_status_r != ST_OK), out_value_r == '0)
  // a finished build leaves the table marked built
  `ASSERT_NEXT(a_built_after_done, (state_r == S_RESP) && (res_status_r == ST_DONE), built_r)

endmodule

// ===== src/ets_div.sv =====
// ----------------------------------------------------------------------------
// ets_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ets_div import ets_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  val_t              dvd_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W-1:0]  rem_r;
  val_t              quo_r;

  logic [DIV_W-1:0]  rem_sh;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;

  assign rem_sh  = {rem_r[DIV_W-2:0], dvd_r[VAL_W-1]};
  assign ge      = (rem_sh >= dvs_r);
  assign rem_nxt = ge ? (rem_sh - dvs_r) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(VAL_W);
        dvd_r  <= req.dividend;
        dvs_r  <= DIV_W'(req.divisor);
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[VAL_W-2:0], 1'b0};
        quo_r <= {quo_r[VAL_W-2:0], ge};
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== tb/sv/euler_totient_sieve_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_sieve_table_checker
// Watches the request, result and limit ports of the totient table. It keeps
// its own sieve table and queues the answer each accepted item should get.
// Every accepted result is compared with the oldest queued answer.
// ----------------------------------------------------------------------------
module euler_totient_sieve_table_checker import ets_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ets_req_if   req,
  ets_rsp_if   rsp,
  input  logic cfg_we,
  input  lim_t cfg_wdata,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned LAST_ENTRY = TABLE_DEPTH - 1;

  typedef struct packed {
    val_t    totient;
    status_t status;
  } answer_t;

  answer_t     pending_answers[$];
  val_t        phi_mirror[TABLE_DEPTH];
  logic        mirror_built;
  int unsigned mirror_built_limit;
  int unsigned limit_reg;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // sieve over 0 .. lim, entries past lim keep what an older build left
  function automatic void sieve_totients(input int unsigned lim);
    int unsigned i;
    int unsigned j;
    for (i = 0; i <= lim; i++) begin
      phi_mirror[i] = val_t'(i);
    end
    for (i = 2; i <= lim; i++) begin
      if (phi_mirror[i] == val_t'(i)) begin
        for (j = i; j <= lim; j += i) begin
          phi_mirror[j] = val_t'(phi_mirror[j] - phi_mirror[j] / i);
        end
      end
    end
  endfunction

  function automatic answer_t answer_query(input lim_t idx);
    answer_t a;
    a.totient = '0;
    if (!mirror_built) begin
      a.status = ST_NOT_BUILT;
    end else if (32'(idx) > mirror_built_limit) begin
      a.status = ST_ABOVE;
    end else begin
      a.totient = phi_mirror[idx];
      a.status  = ST_OK;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    int unsigned lim;
    if (!rst_n) begin
      pending_answers.delete();
      mirror_built       = 1'b0;
      mirror_built_limit = 0;
      limit_reg          = 0;
      fail_count         = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_answers.size() == 0) begin
          report($sformatf("result with nothing outstanding: value %0d status %0d",
                           rsp.totient_value, rsp.status));
        end else begin
          want = pending_answers.pop_front();
          if (rsp.totient_value !== want.totient) begin
            report($sformatf("totient_value got %0d expected %0d (status %s)",
                             rsp.totient_value, want.totient, want.status.name()));
          end
          if (rsp.status !== want.status) begin
            report($sformatf("status got %0d expected %0d",
                             rsp.status, want.status));
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_BUILD) begin
          lim = (limit_reg > LAST_ENTRY) ? LAST_ENTRY : limit_reg;
          sieve_totients(lim);
          mirror_built_limit = lim;
          mirror_built       = 1'b1;
          want.totient       = '0;
          want.status        = ST_DONE;
        end else begin
          want = answer_query(req.query_index);
        end
        pending_answers = {pending_answers, want};
      end
      if (cfg_we) begin
        limit_reg = 32'(cfg_wdata);
      end
    end
    pending = pending_answers.size();
  end

endmodule

// ===== tb/sv/euler_totient_sieve_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_sieve_table_test
// Drives build and query items into the totient sieve table and gives the
// verdict. A short directed run covers queries before any build, limits of
// zero and one, a limit changed after a build and the index extremes. Then
// phases of random items follow, each with its own limit, with random gaps on
// both channels and one long result stall. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module euler_totient_sieve_table_test import ets_pkg::*; ();

  localparam int          RANDOM_ITEMS    = 850;
  // builds above this limit cost too many cycles, so in the random phases
  // such limits are only written and queried against the older table
  localparam int unsigned MAX_BUILD_LIMIT = 1023;
  localparam int          PRESSURE_CYCLES = 400;
  localparam int          DRAIN_CYCLES    = 50;
  // the slowest item is the 4095 build, with no item moving while it runs
  localparam int          WATCHDOG_LIMIT  = 1000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  lim_t cfg_wdata;
  int   fail_count;
  int   pending;

  ets_req_if in_ch ();
  ets_rsp_if out_ch ();

  // shared by both sides: no gaps at all during some phases
  logic no_idle;
  // long result stall, requested by the stimulus and done by the sink side
  logic hold_req;
  logic hold_done;

  // what the stimulus knows, only used to aim queries at useful indices
  lim_t        limit_shadow;
  logic        have_build;
  int unsigned last_build_limit;

  euler_totient_sieve_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  euler_totient_sieve_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_ch),
    .rsp        (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (no_idle) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // most queries land inside the built range, some just past it, some anywhere
  function automatic lim_t pick_index();
    int          roll;
    int unsigned v;
    roll = $urandom_range(0, 99);
    if (have_build && roll < 70) begin
      return lim_t'($urandom_range(0, last_build_limit));
    end
    if (have_build && roll < 85) begin
      v = last_build_limit + $urandom_range(1, 4);
      return lim_t'((v > 65535) ? 65535 : v);
    end
    return lim_t'($urandom_range(0, 65535));
  endfunction

  // small limits keep builds short, the top of the range is written but
  // never built
  function automatic lim_t pick_limit();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return lim_t'(0);
    end
    if (roll < 8) begin
      return lim_t'(1);
    end
    if (roll < 10) begin
      return lim_t'(65535);
    end
    if (roll < 14) begin
      return lim_t'($urandom_range(MAX_BUILD_LIMIT + 1, 65535));
    end
    if (roll < 70) begin
      return lim_t'($urandom_range(0, 63));
    end
    if (roll < 95) begin
      return lim_t'($urandom_range(64, 255));
    end
    return lim_t'($urandom_range(256, MAX_BUILD_LIMIT));
  endfunction

  // offer one item after a random gap, return at the edge that takes it
  task automatic send_item(input logic kind, input lim_t idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.query_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == REQ_BUILD) begin
      last_build_limit = 32'(limit_shadow);
      have_build       = 1'b1;
    end
  endtask

  task automatic ask(input lim_t idx);
    send_item(REQ_QUERY, idx);
  endtask

  // stop offering and wait for every outstanding result, checked at the
  // falling edge so the checker has seen the last rising one
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // only called right after settle, the block is idle here
  task automatic write_limit(input lim_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    limit_shadow  = v;
  endtask

  // sink side: random ready pattern, plus one long stall on request
  initial begin : sink_side
    int gap;
    int burst;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      burst = $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
  end

  // watchdog: ends the run if no item moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("euler_totient_sieve_table_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int   sent;
    int   phase;
    int   count;
    int   k;
    lim_t lim;
    logic buildable;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_BUILD;
    in_ch.query_index = '0;
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    limit_shadow      = '0;
    have_build        = 1'b0;
    last_build_limit  = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // queries before any build answer not built
    ask(lim_t'(0));
    ask(lim_t'(65535));

    // limit zero: only phi(0) exists
    settle();
    write_limit(lim_t'(0));
    send_item(REQ_BUILD, lim_t'(0));
    ask(lim_t'(0));
    ask(lim_t'(1));

    // limit one
    settle();
    write_limit(lim_t'(1));
    send_item(REQ_BUILD, lim_t'(65535));
    ask(lim_t'(1));
    ask(lim_t'(0));

    // top limit written but not built, queries keep the old table and limit
    settle();
    write_limit(lim_t'(65535));
    ask(lim_t'(1));
    ask(lim_t'(65535));
    ask(lim_t'(2));

    // one larger table, primes, powers of two and alternating bit patterns
    settle();
    write_limit(lim_t'(4095));
    send_item(REQ_BUILD, lim_t'(0));
    ask(lim_t'(2));
    ask(lim_t'(4093));
    ask(lim_t'(4095));
    ask(lim_t'(4096));
    ask(lim_t'(3600));
    ask(lim_t'(16'haaaa));
    ask(lim_t'(16'h5555));
    ask(lim_t'(2048));
    ask(lim_t'(65535));

    // random phases: new limit, usually a build first, then mostly queries
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      lim = pick_limit();
      write_limit(lim);
      buildable = (32'(lim) <= MAX_BUILD_LIMIT);
      no_idle   = ($urandom_range(0, 4) == 0);
      count     = $urandom_range(20, 60);
      for (k = 0; k < count; k++) begin
        if (buildable && ((k == 0 && $urandom_range(0, 9) != 0) ||
                          $urandom_range(0, 39) == 0)) begin
          // the index is ignored on a build, send junk there
          send_item(REQ_BUILD, lim_t'($urandom_range(0, 65535)));
        end else begin
          ask(pick_index());
        end
        sent++;
        // long result stall while queries keep coming, fills the block
        if (phase == 1 && k == 2) begin
          hold_req = 1'b1;
        end
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("euler_totient_sieve_table_test: PASS");
    end else begin
      $display("euler_totient_sieve_table_test: FAIL");
    end
    $finish;
  end

endmodule
